// File: rtl/core/tasr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tasr_pkg;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned QUO_W   = 8;
  localparam int unsigned NUM_W   = 2 * QUO_W;

  localparam logic [SPEED_W-1:0] BASE_SPEED_RST  = 8'd100;
  localparam logic [SPEED_W-1:0] EQUAL_SPEED     = 8'd100;
  localparam logic [SPEED_W-1:0] MAX_SPEED       = 8'd255;
  localparam logic [SPEED_W-1:0] MIN_MINOR_SPEED = 8'd60;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    SLOPE_AXIS,
    SLOPE_EQUAL,
    SLOPE_SHALLOW,
    SLOPE_STEEP
  } slope_e;

  typedef struct packed {
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] y_end;
  } in_t;

  typedef struct packed {
    logic [DIR_W-1:0]   x_direction;
    logic [DIR_W-1:0]   y_direction;
    logic [SPEED_W-1:0] x_speed;
    logic [SPEED_W-1:0] y_speed;
  } out_t;

  // Classified segment, handed from front to back
  typedef struct packed {
    dir_e               x_dir;
    dir_e               y_dir;
    slope_e             slope;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [SPEED_W-1:0] base;
    logic [NUM_W-1:0]   num;
  } cmd_t;

  // Sideband carried along the first divider
  typedef struct packed {
    dir_e               x_dir;
    dir_e               y_dir;
    slope_e             slope;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [SPEED_W-1:0] base;
    logic               big;
  } s1_t;

  // Sideband carried along the second divider
  typedef struct packed {
    dir_e               x_dir;
    dir_e               y_dir;
    slope_e             slope;
    logic [SPEED_W-1:0] x_speed;
    logic [SPEED_W-1:0] y_speed;
  } s2_t;

endpackage

`default_nettype wire

// File: rtl/core/tasr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module tasr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tasr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tasr_front (
  input  tasr_pkg::in_t                        item_i,
  input  wire logic [tasr_pkg::SPEED_W-1:0]    base_i,
  output tasr_pkg::cmd_t                       cmd_o
);

  import tasr_pkg::*;

  dir_e               x_dir, y_dir;
  logic [COORD_W-1:0] dx, dy;

  always_comb begin
    if (item_i.x_end > item_i.x_start) begin
      x_dir = DIR_FWD;
      dx    = item_i.x_end - item_i.x_start;
    end else if (item_i.x_end < item_i.x_start) begin
      x_dir = DIR_BWD;
      dx    = item_i.x_start - item_i.x_end;
    end else begin
      x_dir = DIR_STOP;
      dx    = '0;
    end
    if (item_i.y_end > item_i.y_start) begin
      y_dir = DIR_FWD;
      dy    = item_i.y_end - item_i.y_start;
    end else if (item_i.y_end < item_i.y_start) begin
      y_dir = DIR_BWD;
      dy    = item_i.y_start - item_i.y_end;
    end else begin
      y_dir = DIR_STOP;
      dy    = '0;
    end
  end

  always_comb begin
    cmd_o.x_dir = x_dir;
    cmd_o.y_dir = y_dir;
    cmd_o.dx    = dx;
    cmd_o.dy    = dy;
    cmd_o.base  = base_i;
    cmd_o.num   = '0;
    if (x_dir == DIR_STOP || y_dir == DIR_STOP) begin
      cmd_o.slope = SLOPE_AXIS;
    end else if (dx == dy) begin
      cmd_o.slope = SLOPE_EQUAL;
    end else if (dy < dx) begin
      // ceil(60*dx/dy) as floor((60*dx + dy - 1)/dy)
      cmd_o.slope = SLOPE_SHALLOW;
      cmd_o.num   = NUM_W'(dx) * NUM_W'(MIN_MINOR_SPEED) + NUM_W'(dy) - NUM_W'(1);
    end else begin
      cmd_o.slope = SLOPE_STEEP;
      cmd_o.num   = NUM_W'(dx) * NUM_W'(MAX_SPEED);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tasr_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage. Requires num < den * 2**QUO_W.
module tasr_div #(
  parameter int unsigned SIDE_W = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [tasr_pkg::NUM_W-1:0]    num_i,
  input  wire logic [tasr_pkg::QUO_W-1:0]    den_i,
  input  wire logic [SIDE_W-1:0]             side_i,
  output logic                               valid_o,
  output logic [tasr_pkg::QUO_W-1:0]         quo_o,
  output logic [SIDE_W-1:0]                  side_o
);

  import tasr_pkg::*;

  logic [QUO_W-1:0]  vld_q;
  logic [NUM_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  quo_q  [QUO_W];
  logic [QUO_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic              vld_in;
    logic [NUM_W-1:0]  rem_in, rem_d, shifted;
    logic [QUO_W-1:0]  quo_in, quo_d, den_in;
    logic [SIDE_W-1:0] side_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      shifted = NUM_W'(den_in) << (QUO_W - 1 - k);
      quo_d   = quo_in;
      rem_d   = rem_in;
      if (rem_in >= shifted) begin
        rem_d                = rem_in - shifted;
        quo_d[QUO_W - 1 - k] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

`default_nettype wire

// File: rtl/core/tasr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tasr_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  tasr_pkg::cmd_t  cmd_i,
  input  wire logic       cmd_valid_i,
  output logic            cmd_pop_o,
  output tasr_pkg::out_t  res_o,
  output logic            res_valid_o,
  input  wire logic       res_full_i
);

  import tasr_pkg::*;

  logic adv;

  // first divider: x speed bound
  s1_t              s1_in, s1_out;
  logic [NUM_W-1:0] num1;
  logic             d1_valid;
  logic [QUO_W-1:0] q1;

  // middle stage: x speed select and product for y
  logic             m_vld_q;
  s2_t              m_side_q, m_side_d;
  logic [NUM_W-1:0] m_prod_q, m_prod_d;
  logic [QUO_W-1:0] m_dx_q;
  logic [SPEED_W-1:0] vx;

  // second divider: y speed
  s2_t              s2_out;
  logic             d2_valid;
  logic [QUO_W-1:0] q2;

  // Hold the whole pipe only while a finished beat cannot leave
  assign adv       = !(d2_valid && res_full_i);
  assign cmd_pop_o = adv && cmd_valid_i;

  always_comb begin
    s1_in.x_dir = cmd_i.x_dir;
    s1_in.y_dir = cmd_i.y_dir;
    s1_in.slope = cmd_i.slope;
    s1_in.dx    = cmd_i.dx;
    s1_in.dy    = cmd_i.dy;
    s1_in.base  = cmd_i.base;
    s1_in.big   = (cmd_i.num >= {cmd_i.dy, {QUO_W{1'b0}}});
    num1        = '0;
    if ((cmd_i.slope == SLOPE_SHALLOW || cmd_i.slope == SLOPE_STEEP) && !s1_in.big) begin
      num1 = cmd_i.num;
    end
  end

  tasr_div #(
    .SIDE_W ($bits(s1_t))
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (cmd_valid_i),
    .num_i   (num1),
    .den_i   (cmd_i.dy),
    .side_i  (s1_in),
    .valid_o (d1_valid),
    .quo_o   (q1),
    .side_o  (s1_out)
  );

  always_comb begin
    m_side_d.x_dir   = s1_out.x_dir;
    m_side_d.y_dir   = s1_out.y_dir;
    m_side_d.slope   = s1_out.slope;
    m_side_d.y_speed = '0;
    vx               = '0;
    unique case (s1_out.slope)
      SLOPE_AXIS: begin
        vx               = (s1_out.x_dir == DIR_STOP) ? '0 : s1_out.base;
        m_side_d.y_speed = (s1_out.y_dir == DIR_STOP) ? '0 : s1_out.base;
      end
      SLOPE_EQUAL: begin
        vx               = EQUAL_SPEED;
        m_side_d.y_speed = EQUAL_SPEED;
      end
      SLOPE_SHALLOW: begin
        vx = s1_out.big ? MAX_SPEED : ((q1 > s1_out.base) ? q1 : s1_out.base);
      end
      SLOPE_STEEP: begin
        vx = (q1 < s1_out.base) ? q1 : s1_out.base;
      end
      default: begin
        vx = '0;
      end
    endcase
    m_side_d.x_speed = vx;
    m_prod_d         = '0;
    if (s1_out.slope == SLOPE_SHALLOW || s1_out.slope == SLOPE_STEEP) begin
      m_prod_d = NUM_W'(vx) * NUM_W'(s1_out.dy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_side_q <= m_side_d;
      m_prod_q <= m_prod_d;
      m_dx_q   <= s1_out.dx;
    end
  end

  tasr_div #(
    .SIDE_W ($bits(s2_t))
  ) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m_vld_q),
    .num_i   (m_prod_q),
    .den_i   (m_dx_q),
    .side_i  (m_side_q),
    .valid_o (d2_valid),
    .quo_o   (q2),
    .side_o  (s2_out)
  );

  always_comb begin
    res_o.x_direction = s2_out.x_dir;
    res_o.y_direction = s2_out.y_dir;
    res_o.x_speed     = s2_out.x_speed;
    res_o.y_speed     = s2_out.y_speed;
    if (s2_out.slope == SLOPE_SHALLOW || s2_out.slope == SLOPE_STEEP) begin
      res_o.y_speed = q2;
    end
  end

  assign res_valid_o = d2_valid;

endmodule

`default_nettype wire

// File: rtl/core/two_axis_speed_ratio_top.sv
// Path: a result passes the segment queue, the x divider, the speed select and
//   product register and the y divider before it reaches the result queue.
// Throughput: one beat per cycle while the result queue has room; 8-stage dividers.
// Reset (rst_ni low, asynchronous): both queues empty, pipeline drained,
//   base_speed back to 100. No clearing pass; push is taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module two_axis_speed_ratio_top #(
  parameter int unsigned MID_DEPTH = 2,
  parameter int unsigned OUT_DEPTH = 2
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // segment input queue side
  input  wire logic                        push,
  output logic                             full,
  input  tasr_pkg::in_t                    in_i,
  // result queue side
  output logic                             empty,
  input  wire logic                        pop,
  output tasr_pkg::out_t                   out_o,
  // base_speed write channel
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [tasr_pkg::SPEED_W-1:0] cfg_data_i
);

  import tasr_pkg::*;

  logic [SPEED_W-1:0] base_q;
  cmd_t               front_cmd, mid_cmd;
  logic               mid_full, mid_empty, mid_pop;
  out_t               back_res;
  logic               back_valid, out_full;

  // Always ready for a write: the user must change the register only while idle; the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_SPEED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_data_i;
    end
  end

  // Front: find directions, magnitudes and slope class, and build the
  // dividend for the x speed bound. The base speed travels with the beat.
  tasr_front u_front (
    .item_i (in_i),
    .base_i (base_q),
    .cmd_o  (front_cmd)
  );

  // Short queue between front and back; the input side is full when it is.
  tasr_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_cmd),
    .pop_i   (mid_pop),
    .rdata_o (mid_cmd),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  assign full = mid_full;

  // Back: x speed from the first divider, y speed from the second. The
  // whole pipe advances unless a finished beat meets a full result queue.
  tasr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (mid_cmd),
    .cmd_valid_i (!mid_empty),
    .cmd_pop_o   (mid_pop),
    .res_o       (back_res),
    .res_valid_o (back_valid),
    .res_full_i  (out_full)
  );

  // Result queue parts the pipe from the consumer.
  tasr_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid),
    .wdata_i (back_res),
    .pop_i   (pop),
    .rdata_o (out_o),
    .full_o  (out_full),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

// File: rtl/core/tasr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tasr_checker (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  full,
  input wire logic  empty,
  input wire logic  pop,
  input tasr_pkg::out_t out_o
);

  import tasr_pkg::*;

  // Waiting result holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o))
    else $error("result changed while waiting");

  // Queues come out of reset empty and open
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |-> empty && !full)
    else $error("queues not cleared by reset");

  a_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_o.x_direction != 2'd3 && out_o.y_direction != 2'd3)
    else $error("illegal direction code");

  // A stopped axis never gets drive
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_o.x_direction != DIR_STOP || out_o.x_speed == '0) &&
               (out_o.y_direction != DIR_STOP || out_o.y_speed == '0))
    else $error("stopped axis with nonzero speed");

endmodule

bind two_axis_speed_ratio_top tasr_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);

`default_nettype wire

// File: dv/tb_two_axis_speed_ratio_top.sv
`timescale 1ns / 1ps

module tb_two_axis_speed_ratio_top;
  import tasr_pkg::*;

  // Hold the result side off this long to back the pipeline up into full.
  localparam int unsigned HOLD_CYCLES  = 300;
  // Extra drain after the last expected result has been popped.
  localparam int unsigned DRAIN_CYCLES = 25;
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam int unsigned PLAN_ROWS    = 23;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  in_t         in_i;
  logic        empty;
  logic        pop;
  out_t        out_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;

  // Directed plan: base_speed in force, segment, and a typed-in result where it
  // is obvious by inspection; other rows go through the predictor.
  typedef struct {
    logic [7:0] base;
    in_t        seg;
    bit         known;
    out_t       want;
  } plan_row_t;

  plan_row_t plan [PLAN_ROWS] = '{
    // both axes stopped
    '{8'd100, '{8'd0,   8'd0,   8'd0,   8'd0},   1'b1, '{DIR_STOP, DIR_STOP, 8'd0,   8'd0}},
    // one axis stopped, the other at full span each way
    '{8'd100, '{8'd0,   8'd255, 8'd5,   8'd5},   1'b1, '{DIR_FWD,  DIR_STOP, 8'd100, 8'd0}},
    '{8'd100, '{8'd255, 8'd0,   8'd5,   8'd5},   1'b1, '{DIR_BWD,  DIR_STOP, 8'd100, 8'd0}},
    '{8'd100, '{8'd7,   8'd7,   8'd0,   8'd255}, 1'b1, '{DIR_STOP, DIR_FWD,  8'd0,   8'd100}},
    '{8'd100, '{8'd7,   8'd7,   8'd255, 8'd0},   1'b1, '{DIR_STOP, DIR_BWD,  8'd0,   8'd100}},
    // equal slope
    '{8'd100, '{8'd0,   8'd255, 8'd0,   8'd255}, 1'b1, '{DIR_FWD,  DIR_FWD,  8'd100, 8'd100}},
    '{8'd100, '{8'd255, 8'd0,   8'd255, 8'd0},   1'b1, '{DIR_BWD,  DIR_BWD,  8'd100, 8'd100}},
    // shallowest and steepest segments
    '{8'd100, '{8'd0,   8'd255, 8'd0,   8'd1},   1'b1, '{DIR_FWD,  DIR_FWD,  8'd255, 8'd1}},
    '{8'd100, '{8'd0,   8'd1,   8'd0,   8'd255}, 1'b1, '{DIR_FWD,  DIR_FWD,  8'd1,   8'd255}},
    // mild slopes, mixed directions, alternating bit patterns
    '{8'd100, '{8'd0,   8'd4,   8'd0,   8'd3},   1'b0, '0},
    '{8'd100, '{8'd0,   8'd3,   8'd0,   8'd4},   1'b0, '0},
    '{8'd100, '{8'd10,  8'd210, 8'd60,  8'd10},  1'b0, '0},
    '{8'd100, '{8'd20,  8'd10,  8'd0,   8'd200}, 1'b0, '0},
    '{8'd100, '{8'hAA,  8'h55,  8'h55,  8'hAA},  1'b0, '0},
    '{8'd100, '{8'h55,  8'hAA,  8'hAA,  8'h55},  1'b0, '0},
    // base_speed at zero
    '{8'd0,   '{8'd0,   8'd9,   8'd3,   8'd3},   1'b1, '{DIR_FWD,  DIR_STOP, 8'd0,   8'd0}},
    '{8'd0,   '{8'd255, 8'd0,   8'd0,   8'd1},   1'b1, '{DIR_BWD,  DIR_FWD,  8'd255, 8'd1}},
    '{8'd0,   '{8'd0,   8'd1,   8'd255, 8'd0},   1'b1, '{DIR_FWD,  DIR_BWD,  8'd0,   8'd0}},
    '{8'd0,   '{8'd10,  8'd20,  8'd30,  8'd40},  1'b1, '{DIR_FWD,  DIR_FWD,  8'd100, 8'd100}},
    // base_speed at full scale
    '{8'd255, '{8'd9,   8'd9,   8'd200, 8'd100}, 1'b1, '{DIR_STOP, DIR_BWD,  8'd0,   8'd255}},
    '{8'd255, '{8'd0,   8'd1,   8'd0,   8'd255}, 1'b1, '{DIR_FWD,  DIR_FWD,  8'd1,   8'd255}},
    '{8'd255, '{8'd0,   8'd3,   8'd0,   8'd2},   1'b0, '0},
    '{8'd255, '{8'd0,   8'd254, 8'd0,   8'd255}, 1'b0, '0}
  };

  out_t        speeds_due [$];
  logic [7:0]  base_speed_model;
  bit          steady;
  bit          hold_req;
  int unsigned mismatch_count;
  int unsigned segments_sent;
  int unsigned results_checked;
  int unsigned base_writes;
  int unsigned full_stalls;

  two_axis_speed_ratio_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_i        (in_i),
    .empty       (empty),
    .pop         (pop),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Direction and distance of one axis.
  function automatic dir_e axis_motion(logic [7:0] from, logic [7:0] to,
                                       output int unsigned span);
    if (to > from) begin
      span = 32'(to - from);
      return DIR_FWD;
    end
    if (to < from) begin
      span = 32'(from - to);
      return DIR_BWD;
    end
    span = 0;
    return DIR_STOP;
  endfunction

  // Expected directions and speeds for one segment under a given base_speed.
  function automatic out_t predict_speeds(in_t seg, logic [7:0] base);
    int unsigned dx, dy, vx, vy, bound;
    dir_e        xd, yd;
    out_t        res;
    xd = axis_motion(seg.x_start, seg.x_end, dx);
    yd = axis_motion(seg.y_start, seg.y_end, dy);
    if (xd == DIR_STOP || yd == DIR_STOP) begin
      vx = (xd == DIR_STOP) ? 0 : 32'(base);
      vy = (yd == DIR_STOP) ? 0 : 32'(base);
    end else if (dx == dy) begin
      vx = 32'(EQUAL_SPEED);
      vy = 32'(EQUAL_SPEED);
    end else begin
      vx = 32'(base);
      if (dy < dx) begin
        // raise x so that the minor axis still gets its minimum speed
        bound = (32'(MIN_MINOR_SPEED) * dx + dy - 1) / dy;
        if (bound > vx) vx = bound;
        if (vx > 32'(MAX_SPEED)) vx = 32'(MAX_SPEED);
      end else begin
        // lower x so that y stays within full scale
        bound = (32'(MAX_SPEED) * dx) / dy;
        if (bound < vx) vx = bound;
      end
      vy = (vx * dy) / dx;
      if (vy > 32'(MAX_SPEED)) vy = 32'(MAX_SPEED);
    end
    res.x_direction = xd;
    res.y_direction = yd;
    res.x_speed     = vx[7:0];
    res.y_speed     = vy[7:0];
    return res;
  endfunction

  // Place a span of the given length on one axis, in a random direction.
  function automatic void place_axis(int unsigned span, output logic [7:0] from,
                                     output logic [7:0] to);
    int unsigned lo;
    lo = $urandom_range(255 - span);
    if ($urandom_range(1)) begin
      from = 8'(lo);
      to   = 8'(lo + span);
    end else begin
      to   = 8'(lo);
      from = 8'(lo + span);
    end
  endfunction

  // Random segment: plain random in 35 of 100 draws, with stopped axes, equal slopes,
  // near-diagonal ratios and extreme ratios mixed in.
  function automatic in_t random_segment();
    in_t         seg;
    int unsigned kind, a, b;
    int          near;
    kind = $urandom_range(99);
    seg  = $urandom;
    if (kind < 35) begin
      // keep the plain random segment
    end else if (kind < 50) begin
      case ($urandom_range(2))
        0:       seg.x_end = seg.x_start;
        1:       seg.y_end = seg.y_start;
        default: begin
          seg.x_end = seg.x_start;
          seg.y_end = seg.y_start;
        end
      endcase
    end else if (kind < 62) begin
      a = $urandom_range(255, 1);
      place_axis(a, seg.x_start, seg.x_end);
      place_axis(a, seg.y_start, seg.y_end);
    end else if (kind < 80) begin
      a    = $urandom_range(255, 1);
      near = int'(a) + int'($urandom_range(6)) - 3;
      if (near < 1) near = 1;
      if (near > 255) near = 255;
      place_axis(a, seg.x_start, seg.x_end);
      place_axis(near, seg.y_start, seg.y_end);
    end else begin
      a = $urandom_range(255, 200);
      b = $urandom_range(5, 1);
      if ($urandom_range(1)) begin
        place_axis(a, seg.x_start, seg.x_end);
        place_axis(b, seg.y_start, seg.y_end);
      end else begin
        place_axis(b, seg.x_start, seg.x_end);
        place_axis(a, seg.y_start, seg.y_end);
      end
    end
    return seg;
  endfunction

  // Offer one segment, idling first at random unless steady, and wait for its beat.
  // Leave push high afterwards so back-to-back beats need no second assignment.
  task automatic send_segment(in_t seg, bit known, out_t want);
    int unsigned gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 25) gap++;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= seg;
    do @(posedge clk_i); while (full);
    speeds_due.push_back(known ? want : predict_speeds(seg, base_speed_model));
    segments_sent++;
  endtask

  // Drain the block, then write base_speed over its own channel.
  task automatic set_base_speed(logic [7:0] value);
    push <= 1'b0;
    while (speeds_due.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i      <= 1'b0;
    base_speed_model  = value;
    base_writes++;
  endtask

  // Stimulus: reset, directed plan, then random phases under several settings.
  initial begin
    logic [7:0] phase_base [5];
    rst_ni           <= 1'b0;
    push             <= 1'b0;
    in_i             <= '0;
    cfg_valid_i      <= 1'b0;
    cfg_data_i       <= '0;
    base_speed_model  = BASE_SPEED_RST;
    steady            = 1'b0;
    hold_req          = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the plan; rewrite base_speed whenever a row asks for a new one.
    foreach (plan[r]) begin
      if (plan[r].base != base_speed_model) set_base_speed(plan[r].base);
      send_segment(plan[r].seg, plan[r].known, plan[r].want);
    end

    // Phase 1 runs with no idling on either side; phase 2 opens with the
    // result side held off while the sender keeps pushing.
    phase_base = '{8'($urandom_range(254, 1)), 8'd255, 8'd0, 8'd100, 8'($urandom)};
    for (int p = 0; p < 5; p++) begin
      set_base_speed(phase_base[p]);
      steady = (p == 1);
      if (p == 2) begin
        hold_req = 1'b1;
        steady   = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == 80) steady = 1'b0;
        send_segment(random_segment(), 1'b0, '0);
      end
    end
    steady = 1'b0;
    push <= 1'b0;

    // Wait out every result, then drain for DRAIN_CYCLES more to catch strays.
    while (speeds_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d segments (%0d from the directed plan) under %0d base_speed writes",
             segments_sent, PLAN_ROWS, base_writes);
    $display("checked %0d results; input held off by full for %0d cycles",
             results_checked, full_stalls);
    if (mismatch_count == 0) begin
      $display("two_axis_speed_ratio_top regression: pass");
    end else begin
      $display("two_axis_speed_ratio_top regression: fail");
    end
    $finish;
  end

  // Result side: pop at random, steady during the no-idle phase, and hold off
  // for a counted stretch when asked.
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        pop <= steady || ($urandom_range(99) >= 25);
      end
    end
  end

  // Compare every popped beat against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && push && full) full_stalls++;
    if (rst_ni && pop && !empty) begin
      if (speeds_due.size() == 0) begin
        $error("result beat with no expectation waiting: %p", out_o);
        mismatch_count++;
      end else begin
        want = speeds_due.pop_front();
        results_checked++;
        if (out_o.x_direction !== want.x_direction) begin
          $error("x_direction: expected %0d, got %0d", want.x_direction, out_o.x_direction);
          mismatch_count++;
        end
        if (out_o.y_direction !== want.y_direction) begin
          $error("y_direction: expected %0d, got %0d", want.y_direction, out_o.y_direction);
          mismatch_count++;
        end
        if (out_o.x_speed !== want.x_speed) begin
          $error("x_speed: expected %0d, got %0d", want.x_speed, out_o.x_speed);
          mismatch_count++;
        end
        if (out_o.y_speed !== want.y_speed) begin
          $error("y_speed: expected %0d, got %0d", want.y_speed, out_o.y_speed);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", speeds_due.size());
    $display("two_axis_speed_ratio_top regression: fail");
    $finish;
  end

endmodule
